[sv/u8sd_pkg.sv]
// Package for the UTF-8 stream decoder: field widths, byte class constants
// and the decode result type. No dependencies.
package u8sd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 31;
	localparam int unsigned REM_W  = 3;
	localparam int unsigned TDATA_OUT_W = 32;

	// continuation byte: 10xx_xxxx
	localparam logic [BYTE_W-1:0] CONT_TAG_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_TAG      = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_DATA     = 8'h3F;

	// lead byte payload masks for 2..6 byte sequences
	localparam logic [BYTE_W-1:0] LEAD2_DATA = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_DATA = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD4_DATA = 8'h07;
	localparam logic [BYTE_W-1:0] LEAD5_DATA = 8'h03;
	localparam logic [BYTE_W-1:0] LEAD6_DATA = 8'h01;

	// one decoded result
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            decode_error;
	} u8sd_result_t;

endpackage

[sv/utf8_stream_decoder_top.sv]
// UTF-8 stream decoder, top level: input register, byte decode, result register.
// Depends on u8sd_pkg.
//
//  channel  | dir | tdata                  | tuser            | tlast
//  s_axis   | in  | [7:0] byte_in          | -                | end_of_buffer
//  m_axis   | out | [30:0] code_point, [31] 0 | [0] decode_error | -
//
// One byte per clock while the result register is not stalled; a taken byte
// goes to the input register, and its result loads when that byte advances.
// The sequence state (bytes still expected, partial value, discard flag) is
// updated from the registered byte by decode logic, which sets the clock path.
// arst_n clears the valid flags and the sequence state.
// A stalled result register holds the registered byte; the input side then
// stalls too, and moves again on the cycle the result is taken.
module utf8_stream_decoder_top
	import u8sd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] byte_in
	input  logic                   s_axis_tlast,   // end_of_buffer
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [30:0] code_point, [31] zero
	output logic [0:0]             m_axis_tuser    // [0] decode_error
);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// sequence state
	logic [REM_W-1:0]  rem_q;
	logic [CP_W-1:0]   part_q;
	logic              disc_q;

	// result register
	logic              out_valid_q;
	u8sd_result_t      out_q;

	logic              advance;
	logic              accept;

	// decode outputs
	logic              emit;
	u8sd_result_t      res;
	logic [REM_W-1:0]  rem_d;
	logic [CP_W-1:0]   part_d;
	logic              disc_d;
	logic              err;
	logic [CP_W-1:0]   shifted;

	// the registered byte moves on whenever the result register is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign shifted = {part_q[CP_W-7:0], 6'(byte_s1 & CONT_DATA)};

	always_comb begin
		emit            = 1'b0;
		err             = 1'b0;
		res.code_point  = '0;
		res.decode_error = 1'b0;
		rem_d           = rem_q;
		part_d          = part_q;
		disc_d          = disc_q;

		if (disc_q) begin
			// skipping the rest of a failed buffer
		end else if (rem_q == '0) begin
			case (byte_s1) inside
				[8'h00:8'h7F]: begin
					emit           = 1'b1;
					res.code_point = CP_W'(byte_s1);
				end
				[8'h80:8'hBF]: begin
					err = 1'b1;
				end
				[8'hC0:8'hDF]: begin
					rem_d  = REM_W'(1);
					part_d = CP_W'(byte_s1 & LEAD2_DATA);
				end
				[8'hE0:8'hEF]: begin
					rem_d  = REM_W'(2);
					part_d = CP_W'(byte_s1 & LEAD3_DATA);
				end
				[8'hF0:8'hF7]: begin
					rem_d  = REM_W'(3);
					part_d = CP_W'(byte_s1 & LEAD4_DATA);
				end
				[8'hF8:8'hFB]: begin
					rem_d  = REM_W'(4);
					part_d = CP_W'(byte_s1 & LEAD5_DATA);
				end
				default: begin
					// FC..FF, FE/FF included: 6-byte lead
					rem_d  = REM_W'(5);
					part_d = CP_W'(byte_s1 & LEAD6_DATA);
				end
			endcase
		end else if ((byte_s1 & CONT_TAG_MASK) != CONT_TAG) begin
			err = 1'b1;
		end else begin
			rem_d  = rem_q - REM_W'(1);
			part_d = shifted;
			if (rem_q == REM_W'(1)) begin
				emit           = 1'b1;
				res.code_point = shifted;
				part_d         = '0;
			end
		end

		// buffer ends mid-sequence
		if (!disc_q && !err && last_s1 && rem_d != '0)
			err = 1'b1;

		if (err) begin
			emit             = 1'b1;
			res.code_point   = '0;
			res.decode_error = 1'b1;
			rem_d            = '0;
			part_d           = '0;
			disc_d           = 1'b1;
		end

		if (last_s1) begin
			rem_d  = '0;
			part_d = '0;
			disc_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			part_q <= '0;
			disc_q <= 1'b0;
		end else if (advance) begin
			rem_q  <= rem_d;
			part_q <= part_d;
			disc_q <= disc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			out_q <= res;
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {1'b0, out_q.code_point};
	assign m_axis_tuser[0] = out_q.decode_error;

`ifndef SYNTH
	// an error result always carries code point zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("error result with nonzero code point");

	// while discarding no sequence is open
	a_disc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> (rem_q == '0 && part_q == '0))
		else $error("discarding with open sequence");

	// the last byte of a buffer leaves the state cleared
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (rem_q == '0 && !disc_q && part_q == '0))
		else $error("state not cleared after end of buffer");

	// at most five continuation bytes are ever expected
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= REM_W'(5))
		else $error("bytes remaining out of range");
`endif

endmodule

[tb/tb_utf8_stream_decoder_top.sv]
// Self-checking testbench for utf8_stream_decoder_top: byte stream in, code points out.
// Depends on u8sd_pkg and the decoder RTL; a built-in decoder model predicts every result.
module tb_utf8_stream_decoder_top;
	import u8sd_pkg::*;

	localparam int unsigned STALL_LIMIT  = 5000; // cycles with no item moving on either side
	localparam int unsigned RANDOM_ITEMS = 1650;
	localparam int unsigned DRAIN_CYCLES = 8;    // extra wait once all queues have emptied

	// receiver stall patterns, selected by the top two bits of a free-running counter
	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              eob;
		logic              hold; // send only once every expected result is in
	} src_byte_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [BYTE_W-1:0]      s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;

	src_byte_t    byte_q[$];
	u8sd_result_t pending_cp[$];

	// decoder model state
	logic [REM_W-1:0] dec_rem = '0;
	logic [CP_W-1:0]  dec_acc = '0;
	logic             dec_skip = 1'b0;

	logic        in_taken = 1'b0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned mismatch_count = 0;
	logic [9:0]  rx_cycle = '0;
	rx_mode_t    rx_mode;

	utf8_stream_decoder_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eob, input logic hold = 1'b0);
		src_byte_t it;
		it.data = b;
		it.eob  = eob;
		it.hold = hold;
		byte_q.push_back(it);
	endtask

	// Decode one accepted byte; queue the code point or error it yields.
	task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eob);
		logic         bad;
		logic         emit;
		u8sd_result_t r;
		bad  = 1'b0;
		emit = 1'b0;
		r    = '0;
		if (dec_skip) begin
			// rest of a failed buffer: nothing out, end flag clears
			if (eob) begin
				dec_rem  = '0;
				dec_acc  = '0;
				dec_skip = 1'b0;
			end
			return;
		end
		if (dec_rem == 0) begin
			if (b < 8'h80) begin
				emit = 1'b1;
				r.code_point = CP_W'(b);
			end else if (b < 8'hC0) begin
				bad = 1'b1; // continuation byte where a lead belongs
			end else if (b < 8'hE0) begin
				dec_rem = 3'd1;
				dec_acc = CP_W'(b & LEAD2_DATA);
			end else if (b < 8'hF0) begin
				dec_rem = 3'd2;
				dec_acc = CP_W'(b & LEAD3_DATA);
			end else if (b < 8'hF8) begin
				dec_rem = 3'd3;
				dec_acc = CP_W'(b & LEAD4_DATA);
			end else if (b < 8'hFC) begin
				dec_rem = 3'd4;
				dec_acc = CP_W'(b & LEAD5_DATA);
			end else begin
				// FC..FF, FE and FF included: one data bit in the lead
				dec_rem = 3'd5;
				dec_acc = CP_W'(b & LEAD6_DATA);
			end
		end else if ((b & CONT_TAG_MASK) != CONT_TAG) begin
			bad = 1'b1;
		end else begin
			dec_acc = {dec_acc[CP_W-7:0], b[5:0]};
			dec_rem = dec_rem - 3'd1;
			if (dec_rem == 0) begin
				emit = 1'b1;
				r.code_point = dec_acc;
				dec_acc = '0;
			end
		end
		// buffer ends with continuation bytes still owed
		if (!bad && eob && dec_rem != 0)
			bad = 1'b1;
		if (bad) begin
			emit = 1'b1;
			r.code_point   = '0;
			r.decode_error = 1'b1;
			dec_rem  = '0;
			dec_acc  = '0;
			dec_skip = 1'b1;
		end
		if (eob) begin
			dec_rem  = '0;
			dec_acc  = '0;
			dec_skip = 1'b0;
		end
		if (emit)
			pending_cp.push_back(r);
	endtask

	// One buffer: mostly well-formed sequences of 1..6 bytes, sometimes broken.
	// Fault kinds: 1 stray continuation as lead, 2 bad continuation,
	// 3 truncated sequence, 4 raw noise.
	task automatic add_buffer(inout int unsigned counted);
		logic [BYTE_W-1:0] chunk[$];
		logic [BYTE_W-1:0] b;
		int unsigned       nseq;
		int unsigned       len;
		int unsigned       fault;
		int unsigned       pos;
		int unsigned       r;
		logic              injected;
		logic              stop;
		injected = 1'b0;
		stop     = 1'b0;
		fault    = ($urandom_range(0, 99) < 18) ? $urandom_range(1, 4) : 0;
		if (fault == 4) begin
			repeat ($urandom_range(1, 10)) chunk.push_back(BYTE_W'($urandom));
		end else begin
			nseq = $urandom_range(1, 6);
			for (int s = 0; s < nseq && !stop; s++) begin
				r = $urandom_range(0, 9);
				len = (r < 4) ? 1 : (r < 6) ? 2 : (r < 7) ? 3 : (r < 8) ? 4 : (r < 9) ? 5 : 6;
				if (fault == 1 && !injected && (s == nseq - 1 || $urandom_range(0, 1) == 1)) begin
					chunk.push_back({2'b10, 6'($urandom)});
					injected = 1'b1;
					stop     = 1'b1;
				end else begin
					case (len)
						1: b = BYTE_W'($urandom_range(0, 127));
						2: b = {3'b110, 5'($urandom)};
						3: b = {4'b1110, 4'($urandom)};
						4: b = {5'b11110, 3'($urandom)};
						5: b = {6'b111110, 2'($urandom)};
						default: b = {6'b111111, 2'($urandom)};
					endcase
					chunk.push_back(b);
					pos = (len > 1) ? $urandom_range(1, len - 1) : 0;
					for (int k = 1; k < len; k++) begin
						if (fault == 2 && !injected && k == pos) begin
							b = BYTE_W'($urandom);
							if (b[7:6] == 2'b10)
								b[6] = 1'b1;
							chunk.push_back(b);
							injected = 1'b1;
							stop     = 1'b1;
							break;
						end else if (fault == 3 && !injected && k == pos) begin
							// end the buffer right here, mid-sequence
							injected = 1'b1;
							stop     = 1'b1;
							break;
						end else begin
							chunk.push_back({2'b10, 6'($urandom)});
						end
					end
				end
			end
		end
		counted += chunk.size();
		// bytes after an error are skipped by the block, so they do not count
		if (injected && fault != 3)
			repeat ($urandom_range(0, 3)) chunk.push_back(BYTE_W'($urandom));
		foreach (chunk[k])
			push_byte(chunk[k], k == chunk.size() - 1, k == 0 && $urandom_range(0, 149) == 0);
	endtask

	// Stimulus, reset and end of run.
	initial begin
		int unsigned counted;
		counted = 0;

		// ASCII extremes
		push_byte(8'h00, 1'b0);
		push_byte(8'h7F, 1'b1);
		// stray continuation lead, the rest of the buffer is skipped
		push_byte(8'h80, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'hBF, 1'b1);
		// 2-byte extremes
		push_byte(8'hC0, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hDF, 1'b0);
		push_byte(8'hBF, 1'b1);
		// FF lead: all 31 bits set
		push_byte(8'hFF, 1'b0);
		repeat (4) push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b1);
		// bad continuation, then a skipped lead carrying the end flag
		push_byte(8'hE0, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'hC2, 1'b1);
		// FE lead cut short by the end of the buffer
		push_byte(8'hFE, 1'b0);
		push_byte(8'h80, 1'b1);
		// error on the final byte, sent only once the block has drained
		push_byte(8'hA0, 1'b1, 1'b1);

		while (counted < RANDOM_ITEMS)
			add_buffer(counted);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_q.size() != 0 || s_axis_tvalid || pending_cp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_cp.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_cp.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Sender: bursts of random length, random gaps in between.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (byte_q.size() == 0 || (byte_q[0].hold && pending_cp.size() != 0)) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tdata  <= byte_q[0].data;
				s_axis_tlast  <= byte_q[0].eob;
				s_axis_tvalid <= 1'b1;
				byte_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: stall pattern cycles through four modes.
	assign rx_mode = rx_mode_t'(rx_cycle[9:8]);

	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 10'd1;
		case (rx_mode)
			RX_FREE:     m_axis_tready <= 1'b1;
			RX_COIN:     m_axis_tready <= 1'($urandom);
			RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: m_axis_tready <= (rx_cycle % 7 == 0);
			default:     m_axis_tready <= 1'b1;
		endcase
	end

	// Predict on input accept, check on output accept, watch for a hang.
	always @(posedge clk) begin
		u8sd_result_t exp_r;
		in_taken <= s_axis_tvalid && s_axis_tready && arst_n;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tlast);

			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_cp.size() == 0) begin
					$display("%0t: unexpected result: expected none, got code point %h error %b",
						$time, m_axis_tdata[CP_W-1:0], m_axis_tuser[0]);
					mismatch_count++;
				end else begin
					exp_r = pending_cp.pop_front();
					if (m_axis_tdata[CP_W-1:0] !== exp_r.code_point) begin
						$display("%0t: code point mismatch: expected %h, got %h",
							$time, exp_r.code_point, m_axis_tdata[CP_W-1:0]);
						mismatch_count++;
					end
					if (m_axis_tuser[0] !== exp_r.decode_error) begin
						$display("%0t: error flag mismatch: expected %b, got %b",
							$time, exp_r.decode_error, m_axis_tuser[0]);
						mismatch_count++;
					end
					if (m_axis_tdata[TDATA_OUT_W-1:CP_W] !== '0) begin
						$display("%0t: tdata pad mismatch: expected 0, got %b",
							$time, m_axis_tdata[TDATA_OUT_W-1:CP_W]);
						mismatch_count++;
					end
				end
			end

			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, idle_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule
